### design/assert_macros.svh
// assertion macros for the interpolator pipeline
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`endif
`endif

### design/eci_pkg.sv
// types, register indexes and defaults for the eno cubic interpolator
// no dependencies
package eci_pkg;

	localparam int MAX_POINTS_DEF = 1024;
	localparam int FRAC_BITS_DEF  = 16;

	localparam logic [1:0] REG_GRID_ORIGIN  = 2'd0;
	localparam logic [1:0] REG_INVERSE_STEP = 2'd1;
	localparam logic [1:0] REG_LAST_POINT   = 2'd2;

	typedef struct packed {
		logic signed [31:0] sample_0;
		logic signed [31:0] sample_1;
		logic signed [31:0] sample_2;
		logic signed [31:0] sample_3;
		logic signed [31:0] sample_4;
		logic signed [31:0] sample_5;
		logic [10:0]        cell_index;
		logic signed [31:0] query_pos;
	} item_t;

	typedef struct packed {
		logic signed [31:0] interp_value;
		logic               at_boundary;
	} result_t;

	typedef struct packed {
		logic [63:0] p00;
		logic [63:0] p01;
		logic [63:0] p10;
		logic [63:0] p11;
		logic        neg;
	} mul_parts_t;

endpackage

### design/eno_cubic_interpolator.sv
// eno cubic interpolator: stencil choice, newton horner evaluation, rounding
// depends on eci_pkg and assert_macros.svh
//
// channel  signals                        handshake
// input    start, busy, item              accepted when start high, busy low
// result   done, result                   one cycle, receiver cannot stall
// config   cfg_we, cfg_index, cfg_data    written when cfg_we high
//
// twelve register stages; one beat enters every cycle
// busy stays low: the pipeline never stalls, results simply drain in order
// the three 64 bit horner products are split into 32 by 32 partials: one stage forms the partials, another sums them
// reset clears the valid bits and sets the config registers to their defaults
`include "assert_macros.svh"
module eno_cubic_interpolator import eci_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int LW = $clog2(MAX_POINTS + 1);
	localparam int CW = (LW > 12) ? LW : 12;
	localparam logic signed [63:0] LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
	localparam logic [127:0] RND = 128'd1 << (FRAC_BITS - 1);
	localparam logic [63:0] RND64 = 64'd1 << (FRAC_BITS - 1);
	localparam logic [33:0] RECIP3 = 34'h1_5555_5556;
	localparam logic [63:0] SAT_THR = 64'd6 << 31;

	function automatic mul_parts_t mul_split(input logic signed [63:0] a,
		input logic signed [63:0] b);
		mul_parts_t  m;
		logic [63:0] ua;
		logic [63:0] ub;
		ua = a[63] ? 64'(-a) : 64'(a);
		ub = b[63] ? 64'(-b) : 64'(b);
		m.p00 = 64'(ua[31:0]) * 64'(ub[31:0]);
		m.p01 = 64'(ua[31:0]) * 64'(ub[63:32]);
		m.p10 = 64'(ua[63:32]) * 64'(ub[31:0]);
		m.p11 = 64'(ua[63:32]) * 64'(ub[63:32]);
		m.neg = a[63] ^ b[63];
		return m;
	endfunction

	function automatic logic signed [63:0] mul_join(input mul_parts_t m);
		logic [127:0] full;
		logic [127:0] sh;
		logic [63:0]  r;
		full = {64'd0, m.p00} + {32'd0, m.p01, 32'd0} + {32'd0, m.p10, 32'd0}
			+ {m.p11, 64'd0} + RND;
		sh = full >> FRAC_BITS;
		r = (sh > {64'd0, LIM}) ? LIM : sh[63:0];
		return m.neg ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > $signed({1'b0, LIM}))
			return LIM;
		else if (s < -$signed({1'b0, LIM}))
			return -LIM;
		return s[63:0];
	endfunction

	function automatic logic [35:0] abs36(input logic signed [35:0] v);
		return v[35] ? 36'(-v) : 36'(v);
	endfunction

	// config registers
	logic signed [31:0] origin_q;
	logic [30:0]        inv_step_q;
	logic [10:0]        last_point_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q     <= '0;
			inv_step_q   <= 31'd65536;
			last_point_q <= 11'd1024;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_ORIGIN:  origin_q     <= cfg_data;
				REG_INVERSE_STEP: inv_step_q   <= cfg_data[30:0];
				REG_LAST_POINT:   last_point_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// stage 1 inputs
	logic [CW-1:0] last_eff, k_ext, last_ext, max_ext;
	logic signed [35:0] f0, f1, f2, f3, f4, f5;
	logic bnd;

	always_comb begin
		last_ext = CW'(last_point_q);
		max_ext  = CW'(MAX_POINTS);
		last_eff = (last_ext > max_ext) ? max_ext : last_ext;
		k_ext    = CW'(item.cell_index);
		bnd      = (k_ext <= CW'(2)) || ((k_ext + CW'(1)) >= last_eff);
		f0 = {{4{item.sample_0[31]}}, item.sample_0};
		f1 = {{4{item.sample_1[31]}}, item.sample_1};
		f2 = {{4{item.sample_2[31]}}, item.sample_2};
		f3 = {{4{item.sample_3[31]}}, item.sample_3};
		f4 = {{4{item.sample_4[31]}}, item.sample_4};
		f5 = {{4{item.sample_5[31]}}, item.sample_5};
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic bnd_s1, bnd_s2, bnd_s3, bnd_s4, bnd_s5, bnd_s6, bnd_s7, bnd_s8, bnd_s9;
	logic bnd_s10, bnd_s11;
	logic signed [35:0] d2l_s1, d2r_s1, d3a_s1, d3b_s1, d3c_s1;
	logic signed [35:0] c1_s1, c1_s2, c1_s3, c1_s4, c1_s5, c1_s6;
	logic signed [35:0] c0_s1, c0_s2, c0_s3, c0_s4, c0_s5, c0_s6, c0_s7, c0_s8;
	logic signed [32:0] dx_s1;
	logic [10:0]        km1_s1, km1_s2;
	logic signed [35:0] d2_s2, d2_s3, d2_s4, d3_s2, d3_s3;
	logic               left_s2, left_s3;
	logic [63:0]        uprod_s2;
	logic               uneg_s2;
	logic signed [63:0] t_s3, t_s4, t_s5, t_s6, t_s7;
	logic signed [63:0] tm1_s5, acc1_s5, acc2_s7, acc3_s9;
	mul_parts_t         m_s4, m_s6, m_s8;
	logic [32:0]        y_s10;
	logic               big_s10, neg_s10, big_s11, neg_s11;
	logic [66:0]        qprod_s11;
	result_t            res_s12;

	logic signed [63:0] u_c, tm_c, d3e_c, d2e_c, acc_c;
	logic [63:0]        umag_c, mag_c, mag3_c;
	logic [32:0]        dxm_c;
	logic [30:0]        qmag_c;
	logic               lsel_c;

	always_comb begin
		dxm_c  = dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
		lsel_c = abs36(d2l_s1) <= abs36(d2r_s1);
		umag_c = (uprod_s2 + RND64) >> FRAC_BITS;
		u_c    = uneg_s2 ? -$signed(umag_c) : $signed(umag_c);
		tm_c   = t_s3 - (left_s3 ? -ONE : (ONE <<< 1));
		d3e_c  = 64'(d3_s3);
		d2e_c  = 64'(d2_s4);
		acc_c  = acc3_s9;
		mag_c  = acc_c[63] ? 64'(-acc_c) : 64'(acc_c);
		mag3_c = mag_c + 64'd3;
		qmag_c = qprod_s11[64:34];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else begin
			v_s1  <= start;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		// differences
		bnd_s1 <= bnd;
		d2l_s1 <= f3 - (f2 <<< 1) + f1;
		d2r_s1 <= f4 - (f3 <<< 1) + f2;
		d3a_s1 <= f3 - 36'(f2 * 36'sd3) + 36'(f1 * 36'sd3) - f0;
		d3b_s1 <= f4 - 36'(f3 * 36'sd3) + 36'(f2 * 36'sd3) - f1;
		d3c_s1 <= f5 - 36'(f4 * 36'sd3) + 36'(f3 * 36'sd3) - f2;
		c1_s1  <= 36'((f3 - f2) * 36'sd6);
		c0_s1  <= 36'(f2 * 36'sd6);
		dx_s1  <= {item.query_pos[31], item.query_pos} - {origin_q[31], origin_q};
		km1_s1 <= item.cell_index - 11'd1;

		// stencil choice, position product
		bnd_s2   <= bnd_s1;
		left_s2  <= lsel_c;
		d2_s2    <= lsel_c ? d2l_s1 : d2r_s1;
		if (lsel_c)
			d3_s2 <= (abs36(d3a_s1) <= abs36(d3b_s1)) ? d3a_s1 : d3b_s1;
		else
			d3_s2 <= (abs36(d3b_s1) <= abs36(d3c_s1)) ? d3b_s1 : d3c_s1;
		uprod_s2 <= 64'(dxm_c) * 64'(inv_step_q);
		uneg_s2  <= dx_s1[32];
		km1_s2   <= km1_s1;
		c1_s2    <= c1_s1;
		c0_s2    <= c0_s1;

		// grid coordinate
		bnd_s3  <= bnd_s2;
		t_s3    <= u_c - (64'(km1_s2) <<< FRAC_BITS);
		left_s3 <= left_s2;
		d2_s3   <= d2_s2;
		d3_s3   <= d3_s2;
		c1_s3   <= c1_s2;
		c0_s3   <= c0_s2;

		// horner step one
		bnd_s4 <= bnd_s3;
		m_s4   <= mul_split(tm_c, d3e_c);
		t_s4   <= t_s3;
		d2_s4  <= d2_s3;
		c1_s4  <= c1_s3;
		c0_s4  <= c0_s3;

		bnd_s5  <= bnd_s4;
		acc1_s5 <= sadd((d2e_c <<< 1) + d2e_c, mul_join(m_s4));
		tm1_s5  <= t_s4 - ONE;
		t_s5    <= t_s4;
		c1_s5   <= c1_s4;
		c0_s5   <= c0_s4;

		// horner step two
		bnd_s6 <= bnd_s5;
		m_s6   <= mul_split(tm1_s5, acc1_s5);
		t_s6   <= t_s5;
		c1_s6  <= c1_s5;
		c0_s6  <= c0_s5;

		bnd_s7  <= bnd_s6;
		acc2_s7 <= sadd(64'(c1_s6), mul_join(m_s6));
		t_s7    <= t_s6;
		c0_s7   <= c0_s6;

		// horner step three
		bnd_s8 <= bnd_s7;
		m_s8   <= mul_split(t_s7, acc2_s7);
		c0_s8  <= c0_s7;

		bnd_s9  <= bnd_s8;
		acc3_s9 <= sadd(64'(c0_s8), mul_join(m_s8));

		// divide by six, rounded
		bnd_s10 <= bnd_s9;
		big_s10 <= mag3_c >= SAT_THR;
		neg_s10 <= acc_c[63];
		y_s10   <= mag3_c[33:1];

		bnd_s11   <= bnd_s10;
		big_s11   <= big_s10;
		neg_s11   <= neg_s10;
		qprod_s11 <= 67'(y_s10) * 67'(RECIP3);

		res_s12.at_boundary <= bnd_s11;
		if (bnd_s11)
			res_s12.interp_value <= '0;
		else if (big_s11)
			res_s12.interp_value <= neg_s11 ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else
			res_s12.interp_value <= neg_s11 ? -$signed({1'b0, qmag_c})
				: $signed({1'b0, qmag_c});
	end

	assign busy   = 1'b0;
	assign done   = v_s12;
	assign result = res_s12;

	`ASSERT_IMPL(a_latency, clk, arst_n, start, ##12 done)
	`ASSERT_IMPL(a_done_src, clk, arst_n, done, $past(start, 12))
	`ASSERT_IMPL(a_bnd_zero, clk, arst_n, done && result.at_boundary, result.interp_value == '0)

endmodule
